### rtl/prrs_pkg.sv
// Shared types, codes and constants of the portfolio risk and return scorer.
`timescale 1ns / 1ps
package prrs_pkg;

  // Default size of the asset tables.
  localparam int MaxAssetsDef = 5;

  // Field widths.
  localparam int OpW     = 2;
  localparam int AIdxW   = 3;
  localparam int ValW    = 32;
  localparam int RawW    = 16;
  localparam int NormW   = 17;
  localparam int KindW   = 3;
  localparam int NumWPorts = 5;
  localparam int SumW    = 19;

  // Shared divider sizes.
  localparam int DivDW   = 49;
  localparam int DivRW   = 32;
  localparam int DivStepW = 6;
  localparam logic [DivStepW-1:0] WeightSteps = 6'd17;
  localparam logic [DivStepW-1:0] SharpeSteps = 6'd49;

  // Operation codes.
  localparam logic [OpW-1:0] OP_LOAD_MEAN = 2'd0;
  localparam logic [OpW-1:0] OP_LOAD_COV  = 2'd1;
  localparam logic [OpW-1:0] OP_EVALUATE  = 2'd2;
  localparam logic [OpW-1:0] OP_REPORT    = 2'd3;

  // Result kinds.
  localparam logic [KindW-1:0] KIND_EVAL     = 3'd0;
  localparam logic [KindW-1:0] KIND_MIN_RISK = 3'd1;
  localparam logic [KindW-1:0] KIND_MAX_RET  = 3'd2;
  localparam logic [KindW-1:0] KIND_SHARPE   = 3'd3;
  localparam logic [KindW-1:0] KIND_ACK      = 3'd4;

  // Configuration register indexes.
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_ASSET_COUNT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_RISK_FREE   = 1'd1;

  // Reset values.
  localparam logic [AIdxW-1:0] AssetCountReset = 3'd5;
  localparam logic [ValW-1:0]  RiskFreeReset   = 32'd167772;
  localparam logic [ValW-1:0]  SignedMin       = 32'h8000_0000;
  localparam logic [ValW-1:0]  SignedMax       = 32'h7FFF_FFFF;

  typedef struct packed {
    logic                start;
    logic [DivStepW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### rtl/prrs_div.sv
// Restoring divider, one quotient bit per cycle, shared by weight and Sharpe divides.
`timescale 1ns / 1ps
module prrs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  prrs_pkg::div_req_t         req_i,
  input  logic [prrs_pkg::DivRW-1:0] rem_init_i,
  input  logic [prrs_pkg::DivDW-1:0] dividend_i,
  input  logic [prrs_pkg::DivRW-1:0] divisor_i,
  output prrs_pkg::div_sts_t         sts_o,
  output logic [prrs_pkg::DivDW-1:0] quotient_o
);
  import prrs_pkg::*;

  logic [DivRW-1:0]    rem_q;
  logic [DivDW-1:0]    sr_q;
  logic [DivRW-1:0]    dvs_q;
  logic [DivStepW-1:0] cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [DivRW:0]      trial;
  logic [DivRW:0]      diff;
  logic                ge;

  // The dividend bits are consumed from the top while quotient bits enter at
  // the bottom, so after the last step the register holds the quotient.
  assign trial = {rem_q, sr_q[DivDW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      sr_q   <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == 6'd1);
      if (req_i.start) begin
        rem_q  <= rem_init_i;
        sr_q   <= dividend_i;
        dvs_q  <= divisor_i;
        cnt_q  <= req_i.steps;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DivRW-1:0] : trial[DivRW-1:0];
        sr_q  <= {sr_q[DivDW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = sr_q;

endmodule

### rtl/portfolio_risk_return_scorer.sv
// Top level of the portfolio risk and return scorer: sequencer, tables and shared datapath.
// A load answers with one acknowledgement and a report with three transactions, one per kept best.
// An evaluation runs the weight divides, the multiply-accumulates on the one shared multiplier,
// the square-root steps and the Sharpe divide, which zero risk skips; output stalls can hold it.
// Reset clears control, configuration and the kept best portfolios; the tables are unset.
`timescale 1ns / 1ps
module portfolio_risk_return_scorer #(
  parameter int MAX_ASSETS = prrs_pkg::MaxAssetsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [prrs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [prrs_pkg::ValW-1:0]    cfg_wdata_i,
  // Input channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [prrs_pkg::OpW-1:0]     operation_i,
  input  logic [prrs_pkg::AIdxW-1:0]   row_index_i,
  input  logic [prrs_pkg::AIdxW-1:0]   col_index_i,
  input  logic signed [prrs_pkg::ValW-1:0] load_value_i,
  input  logic [prrs_pkg::RawW-1:0]    raw_weight_0_i,
  input  logic [prrs_pkg::RawW-1:0]    raw_weight_1_i,
  input  logic [prrs_pkg::RawW-1:0]    raw_weight_2_i,
  input  logic [prrs_pkg::RawW-1:0]    raw_weight_3_i,
  input  logic [prrs_pkg::RawW-1:0]    raw_weight_4_i,
  // Output channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [prrs_pkg::KindW-1:0]   result_kind_o,
  output logic signed [prrs_pkg::ValW-1:0] expected_return_o,
  output logic [prrs_pkg::ValW-1:0]    risk_o,
  output logic signed [prrs_pkg::ValW-1:0] sharpe_ratio_o,
  output logic [prrs_pkg::NormW-1:0]   norm_weight_0_o,
  output logic [prrs_pkg::NormW-1:0]   norm_weight_1_o,
  output logic [prrs_pkg::NormW-1:0]   norm_weight_2_o,
  output logic [prrs_pkg::NormW-1:0]   norm_weight_3_o,
  output logic [prrs_pkg::NormW-1:0]   norm_weight_4_o,
  output logic                         last_of_run_o
);
  import prrs_pkg::*;

  localparam int IdxW  = $clog2(MAX_ASSETS);
  localparam int ProdW = 62;
  localparam int OpBW  = 44;
  localparam int AccW  = 64;
  localparam int TW    = 52;

  // Sequencer states.
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_ACK     = 5'd1;
  localparam logic [4:0] ST_REP     = 5'd2;
  localparam logic [4:0] ST_WDIV_GO = 5'd3;
  localparam logic [4:0] ST_WDIV_WT = 5'd4;
  localparam logic [4:0] ST_RET_FET = 5'd5;
  localparam logic [4:0] ST_RET_MUL = 5'd6;
  localparam logic [4:0] ST_RET_ACC = 5'd7;
  localparam logic [4:0] ST_ROW_FET = 5'd8;
  localparam logic [4:0] ST_ROW_MUL = 5'd9;
  localparam logic [4:0] ST_ROW_ACC = 5'd10;
  localparam logic [4:0] ST_VAR_FET = 5'd11;
  localparam logic [4:0] ST_VAR_MUL = 5'd12;
  localparam logic [4:0] ST_VAR_ACC = 5'd13;
  localparam logic [4:0] ST_SQRT    = 5'd14;
  localparam logic [4:0] ST_SHP_GO  = 5'd15;
  localparam logic [4:0] ST_SHP_WT  = 5'd16;
  localparam logic [4:0] ST_UPDATE  = 5'd17;
  localparam logic [4:0] ST_EMIT    = 5'd18;

  logic [4:0] state_q;

  // Configuration registers.
  logic [AIdxW-1:0]       asset_count_q;
  logic signed [ValW-1:0] rf_q;

  // Tables; written by loads, read one entry per cycle into a register.
  logic signed [ValW-1:0] mean_q [MAX_ASSETS];
  logic signed [ValW-1:0] cov_q  [MAX_ASSETS][MAX_ASSETS];
  logic signed [ValW-1:0] tab_rd_q;

  // Working registers of one evaluation.
  logic [RawW-1:0]        raw_q [MAX_ASSETS];
  logic [NormW-1:0]       w_q   [MAX_ASSETS];
  logic [SumW-1:0]        sum_q;
  logic [AIdxW-1:0]       n_q;
  logic [IdxW-1:0]        i_q;
  logic [IdxW-1:0]        j_q;
  logic [1:0]             rep_q;
  logic [NormW-1:0]       mul_a_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [TW-1:0]   t_q;
  logic [AccW-1:0]        sq_v_q;
  logic [AccW-1:0]        sq_r_q;
  logic [AccW-1:0]        sq_bit_q;
  logic signed [ValW-1:0] ret_q;
  logic [ValW-1:0]        risk_q;
  logic signed [ValW-1:0] shp_q;
  logic                   neg_q;

  // Kept best portfolios: row 0 minimum risk, row 1 maximum return, row 2 maximum Sharpe.
  logic [ValW-1:0]        top_risk_q;
  logic signed [ValW-1:0] top_ret_q;
  logic signed [ValW-1:0] top_shp_q;
  logic [NormW-1:0]       snap_q [3][MAX_ASSETS];

  // Output register.
  logic                   out_valid_q;
  logic [KindW-1:0]       out_kind_q;
  logic [ValW-1:0]        out_ret_q;
  logic [ValW-1:0]        out_risk_q;
  logic [ValW-1:0]        out_shp_q;
  logic [NormW-1:0]       out_w_q [NumWPorts];
  logic                   out_last_q;

  logic [RawW-1:0]        raw_in [NumWPorts];
  logic                   in_acc;
  logic                   slot_free;
  logic                   res_emit;
  logic [AIdxW-1:0]       n_nx;
  logic [SumW-1:0]        sum_nx;
  logic                   i_last;
  logic                   j_last;
  logic signed [OpBW-1:0] mul_b;
  logic signed [AccW-1:0] acc_nx;
  logic signed [AccW-1:0] ret_sh;
  logic signed [ValW-1:0] ret_sat;
  logic [AccW-1:0]        sq_sum;
  logic                   sq_ge;
  logic [AccW-1:0]        sq_r_nx;
  logic signed [ValW:0]   diff_s;
  logic [ValW:0]          diff_mag;
  logic [DivDW-1:0]       quo;
  logic signed [ValW-1:0] shp_div;
  div_req_t               div_req;
  div_sts_t               div_sts;
  logic [DivRW-1:0]       div_rem_init;
  logic [DivDW-1:0]       div_dividend;
  logic [DivRW-1:0]       div_divisor;

  assign raw_in[0] = raw_weight_0_i;
  assign raw_in[1] = raw_weight_1_i;
  assign raw_in[2] = raw_weight_2_i;
  assign raw_in[3] = raw_weight_3_i;
  assign raw_in[4] = raw_weight_4_i;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  // A result transaction is loaded into the output register in this cycle.
  assign res_emit   = slot_free && (state_q == ST_ACK || state_q == ST_REP
                                    || state_q == ST_EMIT);

  // An asset count of zero acts as one; counts beyond the table size are clipped.
  always_comb begin
    if (asset_count_q == '0) begin
      n_nx = 3'd1;
    end else if (asset_count_q > 3'(MAX_ASSETS)) begin
      n_nx = 3'(MAX_ASSETS);
    end else begin
      n_nx = asset_count_q;
    end
    sum_nx = '0;
    for (int k = 0; k < MAX_ASSETS; k++) begin
      if (3'(k) < n_nx) begin
        sum_nx = sum_nx + SumW'(raw_in[k]);
      end
    end
  end

  assign i_last = (3'(i_q) == n_q - 3'd1);
  assign j_last = (3'(j_q) == n_q - 3'd1);

  // The second multiplier operand is a table entry, or a finished row term
  // scaled down by 2^8 when the variance is being summed.
  assign mul_b  = (state_q == ST_VAR_MUL) ? t_q[TW-1:8] : OpBW'(tab_rd_q);
  assign acc_nx = acc_q + AccW'(prod_q);

  // Return is the floor of the Q.40 sum shifted down by 16, saturated to 32 bits.
  always_comb begin
    ret_sh = acc_nx >>> 16;
    if (ret_sh > AccW'(signed'(SignedMax))) begin
      ret_sat = SignedMax;
    end else if (ret_sh < AccW'(signed'(SignedMin))) begin
      ret_sat = SignedMin;
    end else begin
      ret_sat = ret_sh[ValW-1:0];
    end
  end

  // One step of the bitwise integer square root.
  assign sq_sum  = sq_r_q + sq_bit_q;
  assign sq_ge   = sq_v_q >= sq_sum;
  assign sq_r_nx = sq_ge ? ((sq_r_q >> 1) + sq_bit_q) : (sq_r_q >> 1);

  // Excess return over the risk-free rate, and its magnitude for the divider.
  assign diff_s   = {ret_q[ValW-1], ret_q} - {rf_q[ValW-1], rf_q};
  assign diff_mag = diff_s[ValW] ? (~diff_s + 1'b1) : diff_s;

  // Quotient magnitude back to a signed, saturated Sharpe value.
  always_comb begin
    if (neg_q) begin
      if (quo > DivDW'(33'h0_8000_0000)) begin
        shp_div = SignedMin;
      end else begin
        shp_div = ~quo[ValW-1:0] + 1'b1;
      end
    end else if (quo > DivDW'(SignedMax)) begin
      shp_div = SignedMax;
    end else begin
      shp_div = quo[ValW-1:0];
    end
  end

  // Divider requests: one weight per start, or the Sharpe quotient.
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = WeightSteps;
    div_rem_init  = {17'b0, raw_q[i_q][RawW-1:1]};
    div_dividend  = {raw_q[i_q][0], 48'b0};
    div_divisor   = DivRW'(sum_q);
    if (state_q == ST_WDIV_GO) begin
      div_req.start = 1'b1;
    end else if (state_q == ST_SHP_GO) begin
      div_req.start = (risk_q != '0);
      div_req.steps = SharpeSteps;
      div_rem_init  = '0;
      div_dividend  = {diff_mag, 16'b0};
      div_divisor   = risk_q;
    end
  end

  prrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .rem_init_i (div_rem_init),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quotient_o (quo)
  );

  // Tables and their registered read port.
  always_ff @(posedge clk_i) begin
    if (in_acc && operation_i == OP_LOAD_MEAN && row_index_i < 3'(MAX_ASSETS)) begin
      mean_q[row_index_i[IdxW-1:0]] <= load_value_i;
    end
    if (in_acc && operation_i == OP_LOAD_COV && row_index_i < 3'(MAX_ASSETS)
        && col_index_i < 3'(MAX_ASSETS)) begin
      cov_q[row_index_i[IdxW-1:0]][col_index_i[IdxW-1:0]] <= load_value_i;
    end
    tab_rd_q <= (state_q == ST_RET_FET) ? mean_q[i_q] : cov_q[i_q][j_q];
  end

  // Shared multiplier with its product register.
  always_ff @(posedge clk_i) begin
    prod_q <= $signed({1'b0, mul_a_q}) * mul_b;
  end

  // Sequencer, configuration, working registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      asset_count_q <= AssetCountReset;
      rf_q          <= RiskFreeReset;
      sum_q         <= '0;
      n_q           <= 3'd1;
      i_q           <= '0;
      j_q           <= '0;
      rep_q         <= '0;
      mul_a_q       <= '0;
      acc_q         <= '0;
      t_q           <= '0;
      sq_v_q        <= '0;
      sq_r_q        <= '0;
      sq_bit_q      <= '0;
      ret_q         <= '0;
      risk_q        <= '0;
      shp_q         <= '0;
      neg_q         <= 1'b0;
      top_risk_q    <= '1;
      top_ret_q     <= SignedMin;
      top_shp_q     <= SignedMin;
      out_valid_q   <= 1'b0;
      out_kind_q    <= KIND_EVAL;
      out_ret_q     <= '0;
      out_risk_q    <= '0;
      out_shp_q     <= '0;
      out_last_q    <= 1'b0;
      for (int k = 0; k < MAX_ASSETS; k++) begin
        raw_q[k] <= '0;
        w_q[k]   <= '0;
        for (int c = 0; c < 3; c++) begin
          snap_q[c][k] <= '0;
        end
      end
      for (int k = 0; k < NumWPorts; k++) begin
        out_w_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ASSET_COUNT: asset_count_q <= cfg_wdata_i[AIdxW-1:0];
          CFG_RISK_FREE:   rf_q          <= cfg_wdata_i;
          default: ;
        endcase
      end

      // The output register holds its transaction until the receiver takes it.
      if (res_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (operation_i) inside
              OP_LOAD_MEAN, OP_LOAD_COV: begin
                state_q <= ST_ACK;
              end
              OP_REPORT: begin
                rep_q   <= '0;
                state_q <= ST_REP;
              end
              default: begin
                n_q   <= n_nx;
                sum_q <= sum_nx;
                i_q   <= '0;
                for (int k = 0; k < MAX_ASSETS; k++) begin
                  raw_q[k] <= (3'(k) < n_nx) ? raw_in[k] : '0;
                  w_q[k]   <= '0;
                end
                // A weight sum of zero gives no result and leaves everything as it was.
                state_q <= (sum_nx == '0) ? ST_IDLE : ST_WDIV_GO;
              end
            endcase
          end
        end

        ST_ACK: begin
          if (slot_free) begin
            out_kind_q  <= KIND_ACK;
            out_ret_q   <= '0;
            out_risk_q  <= '0;
            out_shp_q   <= '0;
            out_last_q  <= 1'b1;
            for (int k = 0; k < NumWPorts; k++) begin
              out_w_q[k] <= '0;
            end
            state_q <= ST_IDLE;
          end
        end

        ST_REP: begin
          if (slot_free) begin
            // Each report transaction carries only its own kept value.
            out_risk_q <= (rep_q == 2'd0) ? top_risk_q : '0;
            out_ret_q  <= (rep_q == 2'd1) ? top_ret_q : '0;
            out_shp_q  <= (rep_q == 2'd2) ? top_shp_q : '0;
            out_last_q <= (rep_q == 2'd2);
            case (rep_q)
              2'd0:    out_kind_q <= KIND_MIN_RISK;
              2'd1:    out_kind_q <= KIND_MAX_RET;
              default: out_kind_q <= KIND_SHARPE;
            endcase
            for (int k = 0; k < NumWPorts; k++) begin
              out_w_q[k] <= (k < MAX_ASSETS) ? snap_q[rep_q][k] : '0;
            end
            rep_q   <= rep_q + 2'd1;
            state_q <= (rep_q == 2'd2) ? ST_IDLE : ST_REP;
          end
        end

        ST_WDIV_GO: begin
          state_q <= ST_WDIV_WT;
        end

        ST_WDIV_WT: begin
          if (div_sts.done) begin
            w_q[i_q] <= quo[NormW-1:0];
            if (i_last) begin
              i_q     <= '0;
              acc_q   <= '0;
              state_q <= ST_RET_FET;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= ST_WDIV_GO;
            end
          end
        end

        ST_RET_FET: begin
          mul_a_q <= w_q[i_q];
          state_q <= ST_RET_MUL;
        end

        ST_RET_MUL: begin
          state_q <= ST_RET_ACC;
        end

        ST_RET_ACC: begin
          if (i_last) begin
            ret_q   <= ret_sat;
            acc_q   <= '0;
            t_q     <= '0;
            i_q     <= '0;
            j_q     <= '0;
            state_q <= ST_ROW_FET;
          end else begin
            acc_q   <= acc_nx;
            i_q     <= i_q + 1'b1;
            state_q <= ST_RET_FET;
          end
        end

        ST_ROW_FET: begin
          mul_a_q <= w_q[j_q];
          state_q <= ST_ROW_MUL;
        end

        ST_ROW_MUL: begin
          state_q <= ST_ROW_ACC;
        end

        ST_ROW_ACC: begin
          t_q <= t_q + prod_q[TW-1:0];
          if (j_last) begin
            state_q <= ST_VAR_FET;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_ROW_FET;
          end
        end

        ST_VAR_FET: begin
          mul_a_q <= w_q[i_q];
          state_q <= ST_VAR_MUL;
        end

        ST_VAR_MUL: begin
          state_q <= ST_VAR_ACC;
        end

        ST_VAR_ACC: begin
          acc_q <= acc_nx;
          if (i_last) begin
            // A negative variance from a table that is not positive semidefinite gives zero risk.
            sq_v_q   <= (acc_nx > 0) ? acc_nx : '0;
            sq_r_q   <= '0;
            sq_bit_q <= AccW'(1) << 62;
            state_q  <= ST_SQRT;
          end else begin
            i_q     <= i_q + 1'b1;
            j_q     <= '0;
            t_q     <= '0;
            state_q <= ST_ROW_FET;
          end
        end

        ST_SQRT: begin
          if (sq_ge) begin
            sq_v_q <= sq_v_q - sq_sum;
          end
          sq_r_q   <= sq_r_nx;
          sq_bit_q <= sq_bit_q >> 2;
          if (sq_bit_q[0]) begin
            risk_q  <= sq_r_nx[ValW-1:0];
            state_q <= ST_SHP_GO;
          end
        end

        ST_SHP_GO: begin
          neg_q <= diff_s[ValW];
          if (risk_q == '0) begin
            // Zero risk saturates towards the sign of the excess return.
            if (diff_s == '0) begin
              shp_q <= '0;
            end else if (diff_s[ValW]) begin
              shp_q <= SignedMin;
            end else begin
              shp_q <= SignedMax;
            end
            state_q <= ST_UPDATE;
          end else begin
            state_q <= ST_SHP_WT;
          end
        end

        ST_SHP_WT: begin
          if (div_sts.done) begin
            shp_q   <= shp_div;
            state_q <= ST_UPDATE;
          end
        end

        ST_UPDATE: begin
          if (risk_q < top_risk_q) begin
            top_risk_q <= risk_q;
            for (int k = 0; k < MAX_ASSETS; k++) begin
              snap_q[0][k] <= w_q[k];
            end
          end
          if (ret_q > top_ret_q) begin
            top_ret_q <= ret_q;
            for (int k = 0; k < MAX_ASSETS; k++) begin
              snap_q[1][k] <= w_q[k];
            end
          end
          if (shp_q > top_shp_q) begin
            top_shp_q <= shp_q;
            for (int k = 0; k < MAX_ASSETS; k++) begin
              snap_q[2][k] <= w_q[k];
            end
          end
          state_q <= ST_EMIT;
        end

        ST_EMIT: begin
          if (slot_free) begin
            out_kind_q  <= KIND_EVAL;
            out_ret_q   <= ret_q;
            out_risk_q  <= risk_q;
            out_shp_q   <= shp_q;
            out_last_q  <= 1'b1;
            for (int k = 0; k < NumWPorts; k++) begin
              out_w_q[k] <= (k < MAX_ASSETS) ? w_q[k] : '0;
            end
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = out_kind_q;
  assign expected_return_o = out_ret_q;
  assign risk_o            = out_risk_q;
  assign sharpe_ratio_o    = out_shp_q;
  assign norm_weight_0_o   = out_w_q[0];
  assign norm_weight_1_o   = out_w_q[1];
  assign norm_weight_2_o   = out_w_q[2];
  assign norm_weight_3_o   = out_w_q[3];
  assign norm_weight_4_o   = out_w_q[4];
  assign last_of_run_o     = out_last_q;

endmodule

### tb/sv/tb_portfolio_risk_return_scorer.sv
// Self-checking testbench of the portfolio risk and return scorer.
`timescale 1ns / 1ps
module tb_portfolio_risk_return_scorer;
  import prrs_pkg::*;

  // Where the expected results of a directed row come from. The model-side predictor always
  // runs so that its state follows the block; typed rows replace what it would push.
  typedef enum int {FROM_PREDICTOR, TYPED_ACK, TYPED_RESET_REPORT, TYPED_NOTHING} exp_src_e;

  typedef struct packed {
    logic [OpW-1:0]              op;
    logic [AIdxW-1:0]            row;
    logic [AIdxW-1:0]            col;
    logic [ValW-1:0]             val;
    logic [NumWPorts-1:0][RawW-1:0] raw;
  } portfolio_item_t;

  typedef struct packed {
    logic [KindW-1:0]            kind;
    logic [ValW-1:0]             ret;
    logic [ValW-1:0]             risk;
    logic [ValW-1:0]             sharpe;
    logic [NumWPorts-1:0][NormW-1:0] nw;
    logic                        last;
  } score_result_t;

  typedef struct {
    portfolio_item_t item;
    exp_src_e        src;
  } stim_row_t;

  localparam int SettleCycles = 400;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ValW-1:0] cfg_wdata_i;
  logic in_valid_i, in_stall_o;
  logic [OpW-1:0] operation_i;
  logic [AIdxW-1:0] row_index_i, col_index_i;
  logic signed [ValW-1:0] load_value_i;
  logic [RawW-1:0] raw_weight_0_i, raw_weight_1_i, raw_weight_2_i, raw_weight_3_i,
                   raw_weight_4_i;
  logic out_valid_o, out_stall_i;
  logic [KindW-1:0] result_kind_o;
  logic signed [ValW-1:0] expected_return_o, sharpe_ratio_o;
  logic [ValW-1:0] risk_o;
  logic [NormW-1:0] norm_weight_0_o, norm_weight_1_o, norm_weight_2_o, norm_weight_3_o,
                    norm_weight_4_o;
  logic last_of_run_o;

  portfolio_risk_return_scorer dut (.*);

  // Shadow state of the block: tables, kept best portfolios and configuration.
  int                          mean_tbl [MaxAssetsDef];
  int                          cov_tbl [MaxAssetsDef*MaxAssetsDef];
  bit [31:0]                   top_risk;
  int                          top_ret;
  int                          top_sharpe;
  logic [NumWPorts-1:0][NormW-1:0] best_weights [3];
  bit [2:0]                    asset_cnt;
  int                          risk_free;

  score_result_t pending_results [$];
  int            mismatches;
  int            results_seen;
  int            tx_quiet, rx_quiet;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int clamp32(input longint x);
    if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'sh8000_0000;
    return int'(x);
  endfunction

  function automatic score_result_t make_result(input logic [KindW-1:0] kind,
      input logic [31:0] ret, input logic [31:0] risk, input logic [31:0] sharpe,
      input logic [NumWPorts-1:0][NormW-1:0] nw, input logic last);
    score_result_t r;
    r.kind = kind;
    r.ret = ret;
    r.risk = risk;
    r.sharpe = sharpe;
    r.nw = nw;
    r.last = last;
    return r;
  endfunction

  // Updates the shadow state for one accepted transaction and queues the results it causes.
  function automatic void predict_scores(input portfolio_item_t it, input bit queue_it);
    score_result_t res [$];
    int n;
    longint unsigned total;
    longint wl [MaxAssetsDef];
    logic [NumWPorts-1:0][NormW-1:0] nw;
    longint acc, variance, t, diff;
    int ret, sharpe;
    bit [31:0] risk;
    n = (asset_cnt == 0) ? 1 : ((asset_cnt > MaxAssetsDef) ? MaxAssetsDef : int'(asset_cnt));
    case (it.op)
      OP_LOAD_MEAN, OP_LOAD_COV: begin
        if (it.op == OP_LOAD_MEAN && it.row < MaxAssetsDef)
          mean_tbl[it.row] = it.val;
        if (it.op == OP_LOAD_COV && it.row < MaxAssetsDef && it.col < MaxAssetsDef)
          cov_tbl[it.row*MaxAssetsDef + it.col] = it.val;
        res.push_back(make_result(KIND_ACK, 0, 0, 0, '0, 1'b1));
      end
      OP_REPORT: begin
        res.push_back(make_result(KIND_MIN_RISK, 0, top_risk, 0, best_weights[0], 1'b0));
        res.push_back(make_result(KIND_MAX_RET, top_ret, 0, 0, best_weights[1], 1'b0));
        res.push_back(make_result(KIND_SHARPE, 0, 0, top_sharpe, best_weights[2], 1'b1));
      end
      default: begin
        total = 0;
        for (int i = 0; i < n; i++) total += it.raw[i];
        if (total != 0) begin
          nw = '0;
          for (int i = 0; i < MaxAssetsDef; i++) begin
            wl[i] = (i < n) ? longint'((longint'(it.raw[i]) << 16) / total) : 0;
            nw[i] = wl[i][NormW-1:0];
          end
          acc = 0;
          for (int i = 0; i < n; i++) acc += wl[i] * longint'(mean_tbl[i]);
          ret = clamp32(acc >>> 16);
          variance = 0;
          for (int i = 0; i < n; i++) begin
            t = 0;
            for (int j = 0; j < n; j++) t += wl[j] * longint'(cov_tbl[i*MaxAssetsDef + j]);
            variance += wl[i] * (t >>> 8);
          end
          risk = (variance > 0) ? int_sqrt(variance) : 0;
          diff = longint'(ret) - longint'(risk_free);
          // Zero risk saturates the Sharpe value according to the sign of the excess return.
          if (risk == 0)
            sharpe = (diff > 0) ? 32'sh7FFF_FFFF : ((diff < 0) ? 32'sh8000_0000 : 0);
          else
            sharpe = clamp32((diff * 65536) / longint'({32'd0, risk}));
          if (risk < top_risk) begin
            top_risk = risk;
            best_weights[0] = nw;
          end
          if (ret > top_ret) begin
            top_ret = ret;
            best_weights[1] = nw;
          end
          if (sharpe > top_sharpe) begin
            top_sharpe = sharpe;
            best_weights[2] = nw;
          end
          res.push_back(make_result(KIND_EVAL, ret, risk, sharpe, nw, 1'b1));
        end
      end
    endcase
    if (queue_it)
      foreach (res[k]) pending_results.push_back(res[k]);
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch with none at all.
  function automatic int draw_gap(ref int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) quiet = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 5);
    return $urandom_range(15, 60);
  endfunction

  // Offers one transaction, waits for the handshake, then predicts and maybe pauses.
  task automatic send_item(input portfolio_item_t it, input exp_src_e src);
    int gap;
    operation_i    <= it.op;
    row_index_i    <= it.row;
    col_index_i    <= it.col;
    load_value_i   <= it.val;
    raw_weight_0_i <= it.raw[0];
    raw_weight_1_i <= it.raw[1];
    raw_weight_2_i <= it.raw[2];
    raw_weight_3_i <= it.raw[3];
    raw_weight_4_i <= it.raw[4];
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_scores(it, src == FROM_PREDICTOR);
    case (src)
      TYPED_ACK: pending_results.push_back(make_result(KIND_ACK, 0, 0, 0, '0, 1'b1));
      TYPED_RESET_REPORT: begin
        pending_results.push_back(make_result(KIND_MIN_RISK, 0, 32'hFFFF_FFFF, 0, '0, 1'b0));
        pending_results.push_back(make_result(KIND_MAX_RET, SignedMin, 0, 0, '0, 1'b0));
        pending_results.push_back(make_result(KIND_SHARPE, 0, 0, SignedMin, '0, 1'b1));
      end
      default: ;
    endcase
    gap = draw_gap(tx_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits until every expected result has come and any result-less evaluation has drained.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Drives one register write for a cycle; the caller drops the write enable afterwards.
  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [ValW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == CFG_ASSET_COUNT) asset_cnt = data[2:0];
    else risk_free = data;
  endtask

  function automatic portfolio_item_t mk_item(input logic [OpW-1:0] op,
      input logic [AIdxW-1:0] row, input logic [AIdxW-1:0] col, input logic [ValW-1:0] val,
      input logic [RawW-1:0] w0, input logic [RawW-1:0] w1, input logic [RawW-1:0] w2,
      input logic [RawW-1:0] w3, input logic [RawW-1:0] w4);
    portfolio_item_t it;
    it.op = op;
    it.row = row;
    it.col = col;
    it.val = val;
    it.raw = {w4, w3, w2, w1, w0};
    return it;
  endfunction

  // Loads every in-range table entry. A tame table keeps the covariance close to positive
  // definite with positive diagonals; a wild one uses full-range values.
  task automatic fill_tables(input bit wild);
    int v;
    for (int i = 0; i < MaxAssetsDef; i++) begin
      v = wild ? int'($urandom) : int'($urandom_range(0, 1 << 24)) - (1 << 23);
      send_item(mk_item(OP_LOAD_MEAN, i, 0, v, 0, 0, 0, 0, 0), FROM_PREDICTOR);
    end
    for (int i = 0; i < MaxAssetsDef; i++)
      for (int j = 0; j < MaxAssetsDef; j++) begin
        if (wild) v = int'($urandom);
        else if (i == j) v = $urandom_range(1 << 20, 1 << 26);
        else if (j < i) v = cov_tbl[j*MaxAssetsDef + i];
        else v = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        send_item(mk_item(OP_LOAD_COV, i, j, v, 0, 0, 0, 0, 0), FROM_PREDICTOR);
      end
  endtask

  function automatic portfolio_item_t random_item();
    portfolio_item_t it;
    int r, style, pick;
    it = mk_item($urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 7), $urandom,
                 0, 0, 0, 0, 0);
    r = $urandom_range(0, 99);
    if (r < 68) it.op = OP_EVALUATE;
    else if (r < 78) it.op = OP_REPORT;
    else if (r < 89) it.op = OP_LOAD_MEAN;
    else it.op = OP_LOAD_COV;
    // Most indexes address the table; a few fall outside it and must be dropped.
    if ($urandom_range(0, 3) != 0) begin
      it.row = $urandom_range(0, MaxAssetsDef - 1);
      it.col = $urandom_range(0, MaxAssetsDef - 1);
    end
    style = $urandom_range(0, 99);
    pick = $urandom_range(0, NumWPorts - 1);
    for (int i = 0; i < NumWPorts; i++) begin
      if (style < 40) it.raw[i] = $urandom;
      else if (style < 60) it.raw[i] = $urandom_range(0, 15);
      else if (style < 75) it.raw[i] = (i == pick) ? 16'($urandom_range(1, 65535)) : 16'd0;
      else if (style < 96) it.raw[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else it.raw[i] = 0;
    end
    return it;
  endfunction

  // Receiver: random stalls, plus one long hold-off once results are flowing so that the
  // block fills up and stalls the sender.
  initial begin
    bit held;
    int gap;
    held = 1'b0;
    rx_quiet = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= 80) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (2000) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        gap = draw_gap(rx_quiet);
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
      end
    end
  end

  // Checks each accepted result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    score_result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      got = make_result(result_kind_o, expected_return_o, risk_o, sharpe_ratio_o,
                        {norm_weight_4_o, norm_weight_3_o, norm_weight_2_o, norm_weight_1_o,
                         norm_weight_0_o}, last_of_run_o);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch:\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

  initial begin
    stim_row_t directed [$];
    int rf_values [8];
    bit [2:0] count_values [8];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_ASSET_COUNT;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    operation_i = OP_LOAD_MEAN;
    row_index_i = '0;
    col_index_i = '0;
    load_value_i = '0;
    raw_weight_0_i = '0;
    raw_weight_1_i = '0;
    raw_weight_2_i = '0;
    raw_weight_3_i = '0;
    raw_weight_4_i = '0;
    mismatches = 0;
    results_seen = 0;
    tx_quiet = 0;
    foreach (mean_tbl[i]) mean_tbl[i] = 0;
    foreach (cov_tbl[i]) cov_tbl[i] = 0;
    top_risk = 32'hFFFF_FFFF;
    top_ret = SignedMin;
    top_sharpe = SignedMin;
    foreach (best_weights[i]) best_weights[i] = '0;
    asset_cnt = AssetCountReset;
    risk_free = RiskFreeReset;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Nothing has been evaluated yet, so the report in the first row still shows reset values.
    fill_tables(1'b0);
    directed.push_back('{mk_item(OP_REPORT, 0, 0, 0, 0, 0, 0, 0, 0), TYPED_RESET_REPORT});
    // Writes outside the tables are dropped but still acknowledged.
    directed.push_back('{mk_item(OP_LOAD_MEAN, 5, 0, SignedMax, 0, 0, 0, 0, 0), TYPED_ACK});
    directed.push_back('{mk_item(OP_LOAD_MEAN, 7, 7, SignedMin, 0, 0, 0, 0, 0), TYPED_ACK});
    directed.push_back('{mk_item(OP_LOAD_COV, 5, 0, SignedMax, 0, 0, 0, 0, 0), TYPED_ACK});
    directed.push_back('{mk_item(OP_LOAD_COV, 0, 7, SignedMin, 0, 0, 0, 0, 0), TYPED_ACK});
    // An all-zero weight sum yields no result and leaves the kept portfolios alone.
    directed.push_back('{mk_item(OP_EVALUATE, 0, 0, 0, 0, 0, 0, 0, 0), TYPED_NOTHING});
    directed.push_back('{mk_item(OP_EVALUATE, 0, 0, 0, '1, '1, '1, '1, '1), FROM_PREDICTOR});
    directed.push_back('{mk_item(OP_EVALUATE, 0, 0, 0, '1, 0, 0, 0, 0), FROM_PREDICTOR});
    directed.push_back('{mk_item(OP_EVALUATE, 0, 0, 0, 1, 0, 0, 0, '1), FROM_PREDICTOR});
    directed.push_back('{mk_item(OP_EVALUATE, 0, 0, 0, 1, 0, 0, 0, 0), FROM_PREDICTOR});
    directed.push_back('{mk_item(OP_EVALUATE, 0, 0, 0, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
                                 16'h8001), FROM_PREDICTOR});
    // Asset four alone with a zero variance gives zero risk: the Sharpe value saturates up,
    // down, or is zero when the return equals the risk-free rate.
    directed.push_back('{mk_item(OP_LOAD_COV, 4, 4, 0, 0, 0, 0, 0, 0), TYPED_ACK});
    directed.push_back('{mk_item(OP_LOAD_MEAN, 4, 0, SignedMax, 0, 0, 0, 0, 0), TYPED_ACK});
    directed.push_back('{mk_item(OP_EVALUATE, 0, 0, 0, 0, 0, 0, 0, '1), FROM_PREDICTOR});
    directed.push_back('{mk_item(OP_LOAD_MEAN, 4, 0, SignedMin, 0, 0, 0, 0, 0), TYPED_ACK});
    directed.push_back('{mk_item(OP_EVALUATE, 0, 0, 0, 0, 0, 0, 0, 1), FROM_PREDICTOR});
    directed.push_back('{mk_item(OP_LOAD_MEAN, 4, 0, RiskFreeReset, 0, 0, 0, 0, 0), TYPED_ACK});
    directed.push_back('{mk_item(OP_EVALUATE, 0, 0, 0, 0, 0, 0, 0, 300), FROM_PREDICTOR});
    directed.push_back('{mk_item(OP_REPORT, 0, 0, 0, 0, 0, 0, 0, 0), FROM_PREDICTOR});
    foreach (directed[k]) send_item(directed[k].item, directed[k].src);

    // Random phases, each under its own configuration; the extremes of both registers and
    // asset counts outside the legal range are among them.
    count_values = '{3'd5, 3'd1, 3'd0, 3'd7, 3'd3, 3'd2, 3'd6, 3'd4};
    rf_values = '{RiskFreeReset, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, $urandom, -167772,
                  $urandom_range(0, 1 << 24), 1 << 20};
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_cfg(CFG_ASSET_COUNT, {29'd0, count_values[p]});
      write_cfg(CFG_RISK_FREE, rf_values[p]);
      cfg_we_i <= 1'b0;
      if (p % 2 == 1) fill_tables(p == 5);
      repeat (45) send_item(random_item(), FROM_PREDICTOR);
    end

    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
